### sv/utv_pkg.sv
// shared constants and helpers for the utf-8 text validator
package utv_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;
    localparam int unsigned PND_W = 2;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;

    localparam logic [CP_W-1:0] MIN_CP3   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP4   = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

    typedef logic [CP_W-1:0]  cp_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [PND_W-1:0] pend_t;

    // overlong, surrogate or beyond the unicode range
    function automatic logic bad_code_point(input len_t len, input cp_t cp);
        logic bad;
        bad = ((len == LEN_3) && (cp < MIN_CP3)) ||
              ((len == LEN_4) && (cp < MIN_CP4)) ||
              ((cp >= SURR_LO) && (cp <= SURR_HI)) ||
              (cp > MAX_CP);
        return bad;
    endfunction

endpackage

### sv/utf8_text_validator.sv
// utf-8 text validator top level: byte decoder with one verdict per text
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------
//  in      | input     | in_valid / in_ready   | byte_value, end_of_text
//  out     | output    | out_valid / out_ready | text_valid
//
// one word per clock sustained unless a final word waits on a held verdict;
// each word passes the input register, each verdict then the result register
// the decoder state (pending count, length, code point, failure flag) updates
// when a word leaves the input register, so the throughput is set by that stage
// reset clears all valid flags and the decoder state
// a stalled verdict holds the final word in the input register; ordinary words
// keep flowing through the decoder while a verdict waits to be taken
module utf8_text_validator
    import utv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       text_valid
);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eot_reg;

    // decoder state
    pend_t bytes_pending_reg, bytes_pending_next;
    len_t  char_length_reg,   char_length_next;
    cp_t   code_point_reg,    code_point_next;
    logic  failed_reg,        failed_next;

    // result register
    logic out_valid_reg;
    logic text_valid_reg, text_valid_next;

    logic s1_advance;
    logic in_accept;
    logic forbidden;
    logic [7:0] b;

    assign b = s1_byte_reg;

    // a final word needs room in the result register, others always move on
    assign s1_advance = s1_valid_reg && (!s1_eot_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // nul, other controls except newline and tab, and delete
    assign forbidden = ((b < CTRL_LIMIT) && (b != CHAR_LF) && (b != CHAR_TAB)) ||
                       (b == CHAR_DEL);

    // one decode step on the word in the input register
    always_comb
    begin
        bytes_pending_next = bytes_pending_reg;
        char_length_next   = char_length_reg;
        code_point_next    = code_point_reg;
        failed_next        = failed_reg;
        if (!failed_reg)
        begin
            if (bytes_pending_reg == '0)
            begin
                // lead byte
                priority if (forbidden)
                begin
                    failed_next = 1'b1;
                end
                else if (b <= CHAR_DEL)
                begin
                    char_length_next   = LEN_1;
                    code_point_next    = {{(CP_W-8){1'b0}}, b};
                    bytes_pending_next = pend_t'(0);
                end
                else if ((b & LEAD2_MASK) == LEAD2_PAT)
                begin
                    char_length_next   = LEN_2;
                    code_point_next    = {{(CP_W-5){1'b0}}, b[4:0]};
                    bytes_pending_next = pend_t'(1);
                    // 0xc0 and 0xc1 only encode overlong ascii
                    if (b[4:1] == 4'd0)
                    begin
                        failed_next = 1'b1;
                    end
                end
                else if ((b & LEAD3_MASK) == LEAD3_PAT)
                begin
                    char_length_next   = LEN_3;
                    code_point_next    = {{(CP_W-4){1'b0}}, b[3:0]};
                    bytes_pending_next = pend_t'(2);
                end
                else if ((b & LEAD4_MASK) == LEAD4_PAT)
                begin
                    char_length_next   = LEN_4;
                    code_point_next    = {{(CP_W-3){1'b0}}, b[2:0]};
                    bytes_pending_next = pend_t'(3);
                end
                else
                begin
                    // stray continuation or 0xf8 and above
                    failed_next = 1'b1;
                end
            end
            else
            begin
                // continuation byte
                if ((b & CONT_MASK) != CONT_PAT)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    code_point_next    = {code_point_reg[CP_W-7:0], b[5:0]};
                    bytes_pending_next = bytes_pending_reg - pend_t'(1);
                    if ((bytes_pending_next == '0) &&
                        bad_code_point(char_length_reg, code_point_next))
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
        end
        // a cut-off character also makes the text invalid
        text_valid_next = !failed_next && (bytes_pending_next == '0);
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= byte_value;
            s1_eot_reg  <= end_of_text;
        end
    end

    // decoder state, cleared after every final word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_pending_reg <= '0;
            char_length_reg   <= LEN_NONE;
            code_point_reg    <= '0;
            failed_reg        <= 1'b0;
        end
        else if (s1_advance)
        begin
            if (s1_eot_reg)
            begin
                bytes_pending_reg <= '0;
                char_length_reg   <= LEN_NONE;
                code_point_reg    <= '0;
                failed_reg        <= 1'b0;
            end
            else
            begin
                bytes_pending_reg <= bytes_pending_next;
                char_length_reg   <= char_length_next;
                code_point_reg    <= code_point_next;
                failed_reg        <= failed_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_eot_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_eot_reg)
        begin
            text_valid_reg <= text_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign text_valid = text_valid_reg;

endmodule

### sv/utv_checker.sv
// port-level checker for the utf-8 text validator and its bind
module utv_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_text,
    input logic       out_valid,
    input logic       out_ready,
    input logic       text_valid
);

    // final words taken but whose verdict is not yet delivered
    logic [1:0] open_texts_reg, open_texts_next;
    logic       eot_in;
    logic       res_out;

    assign eot_in  = in_valid && in_ready && end_of_text;
    assign res_out = out_valid && out_ready;

    always_comb
    begin
        open_texts_next = open_texts_reg + 2'(eot_in) - 2'(res_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_texts_reg <= 2'd0;
        end
        else
        begin
            open_texts_reg <= open_texts_next;
        end
    end

    // no verdict without a final word before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (open_texts_reg != 2'd0))
        else $error("verdict without a pending text");

    // at most one text in the input register and one in the result register
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (open_texts_reg == 2'd0) || (open_texts_reg == 2'd1) || (open_texts_reg == 2'd2))
        else $error("too many texts in flight");

    // with nothing buffered the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (open_texts_reg == 2'd0) |-> in_ready)
        else $error("input stalled with no pending verdict");

    // a waiting verdict holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(text_valid)))
        else $error("verdict dropped or changed while stalled");

endmodule

bind utf8_text_validator utv_checker u_utv_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .text_valid  (text_valid)
);

### tb/sv/tb_utf8_text_validator.sv
// testbench for the utf-8 text validator: directed table, random texts, scoreboard
module tb_utf8_text_validator;
    timeunit 1ns;
    timeprecision 1ps;

    import utv_pkg::*;

    // table flags: verdict typed into the row, or left to the decoder model
    localparam logic KNOWN   = 1'b1;
    localparam logic PRED    = 1'b0;
    localparam logic VALID   = 1'b1;
    localparam logic INVALID = 1'b0;

    localparam int unsigned RANDOM_WORDS = 950;
    // no idling on either side once this many random words have gone in
    localparam int unsigned QUIET_TAIL   = 800;
    localparam int unsigned MAX_PRINTS   = 30;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] byte_value  = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic       text_valid;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       known;
        logic       verdict;
    } dir_row_t;

    typedef struct {
        logic        verdict;
        int unsigned text_no;
    } verdict_exp_t;

    // directed words; the verdict column only matters on rows that end a text
    dir_row_t directed_rows [26] = '{
        '{8'h41, 1'b1, KNOWN, VALID},    // plain ascii straight after reset
        '{8'h00, 1'b1, KNOWN, INVALID},  // nul
        '{8'h09, 1'b0, PRED,  INVALID},  // tab and newline are the allowed controls
        '{8'h0A, 1'b1, PRED,  INVALID},
        '{8'h1F, 1'b1, KNOWN, INVALID},  // top of the control range
        '{8'h7F, 1'b1, KNOWN, INVALID},  // del
        '{8'h80, 1'b1, KNOWN, INVALID},  // continuation where a lead belongs
        '{8'hFF, 1'b1, KNOWN, INVALID},  // all ones, never a lead
        '{8'hC1, 1'b0, PRED,  INVALID},  // overlong two-byte lead
        '{8'hBF, 1'b1, KNOWN, INVALID},
        '{8'hDF, 1'b0, PRED,  INVALID},  // largest two-byte character
        '{8'hBF, 1'b1, PRED,  INVALID},
        '{8'hE0, 1'b0, PRED,  INVALID},  // overlong three-byte form of nul
        '{8'h80, 1'b0, PRED,  INVALID},
        '{8'h80, 1'b1, KNOWN, INVALID},
        '{8'hED, 1'b0, PRED,  INVALID},  // first surrogate
        '{8'hA0, 1'b0, PRED,  INVALID},
        '{8'h80, 1'b1, KNOWN, INVALID},
        '{8'hF4, 1'b0, PRED,  INVALID},  // one past the last code point
        '{8'h90, 1'b0, PRED,  INVALID},
        '{8'h80, 1'b0, PRED,  INVALID},
        '{8'h80, 1'b1, KNOWN, INVALID},
        '{8'hE2, 1'b0, PRED,  INVALID},  // character cut off by the end of text
        '{8'h82, 1'b1, KNOWN, INVALID},
        '{8'hC3, 1'b0, PRED,  INVALID},  // two-byte lead, then a bad continuation that ends the text
        '{8'h41, 1'b1, KNOWN, INVALID}
    };

    // decoder model state
    pend_t dec_pending;
    len_t  dec_len;
    cp_t   dec_cp;
    logic  dec_failed;

    verdict_exp_t expected_verdicts [$];
    logic [7:0]   text_bytes [$];

    int unsigned in_gap_pct    = 0;
    int unsigned out_stall_pct = 0;
    int unsigned mismatches    = 0;
    int unsigned words_sent    = 0;
    int unsigned texts_sent    = 0;
    int unsigned verdicts_seen = 0;
    int unsigned verdicts_good = 0;

    utf8_text_validator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_value  (byte_value),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_valid  (text_valid)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous cap, far above the slowest legal run
    initial begin
        #(2_000_000);
        $display("timeout with %0d verdicts outstanding", expected_verdicts.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic clear_decoder();
        dec_pending = '0;
        dec_len     = LEN_NONE;
        dec_cp      = '0;
        dec_failed  = 1'b0;
    endtask

    // append one byte to the text being built
    task automatic add_byte(input logic [7:0] v);
        text_bytes.insert(text_bytes.size(), v);
    endtask

    // a finished character fails if overlong, a surrogate or past the unicode range
    task automatic close_char();
        if ((dec_len == LEN_3 && dec_cp < MIN_CP3) ||
            (dec_len == LEN_4 && dec_cp < MIN_CP4) ||
            (dec_cp >= SURR_LO && dec_cp <= SURR_HI) ||
            dec_cp > MAX_CP)
            dec_failed = 1'b1;
    endtask

    // present one word, hold it until taken, then run it through the decoder model
    task automatic send_word(input logic [7:0] data, input logic last,
                             input logic known, input logic known_verdict);
        verdict_exp_t want;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        byte_value  <= data;
        end_of_text <= last;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;

        // once failed, the rest of the text is not decoded
        if (!dec_failed) begin
            if (dec_pending == '0) begin
                if (data == 8'h00 || (data < CTRL_LIMIT && data != CHAR_LF &&
                    data != CHAR_TAB) || data == CHAR_DEL) begin
                    dec_failed = 1'b1;
                end else if (!data[7]) begin
                    dec_len = LEN_1;
                    dec_cp  = cp_t'(data);
                    close_char();
                end else if ((data & LEAD2_MASK) == LEAD2_PAT) begin
                    dec_len     = LEN_2;
                    dec_cp      = cp_t'(data[4:0]);
                    dec_pending = pend_t'(1);
                    // 0xc0 and 0xc1 can only encode ascii
                    if (data[4:1] == 4'h0)
                        dec_failed = 1'b1;
                end else if ((data & LEAD3_MASK) == LEAD3_PAT) begin
                    dec_len     = LEN_3;
                    dec_cp      = cp_t'(data[3:0]);
                    dec_pending = pend_t'(2);
                end else if ((data & LEAD4_MASK) == LEAD4_PAT) begin
                    dec_len     = LEN_4;
                    dec_cp      = cp_t'(data[2:0]);
                    dec_pending = pend_t'(3);
                end else begin
                    dec_failed = 1'b1;
                end
            end else if ((data & CONT_MASK) != CONT_PAT) begin
                dec_failed = 1'b1;
            end else begin
                dec_cp      = {dec_cp[CP_W-7:0], data[5:0]};
                dec_pending = dec_pending - pend_t'(1);
                if (dec_pending == '0)
                    close_char();
            end
        end

        if (last) begin
            want.verdict = known ? known_verdict : (!dec_failed && dec_pending == '0);
            want.text_no = texts_sent;
            expected_verdicts.insert(expected_verdicts.size(), want);
            texts_sent++;
            clear_decoder();
        end
    endtask

    // result side back-pressure in random bursts
    initial begin
        forever begin
            @(posedge clk);
            if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // verdict scoreboard, sampled on the edge that completes the handshake
    always @(posedge clk) begin
        verdict_exp_t want;
        if (rst_n && out_valid && out_ready) begin
            verdicts_seen++;
            if (text_valid)
                verdicts_good++;
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %0b with no text outstanding",
                                          text_valid));
            end else begin
                want = expected_verdicts.pop_front();
                if (text_valid !== want.verdict)
                    report_mismatch($sformatf("text %0d: text_valid %0b, expected %0b",
                                              want.text_no, text_valid, want.verdict));
            end
        end
    end

    initial begin
        int unsigned random_words;
        int unsigned n_chars;
        int unsigned kind;
        int unsigned cp;
        int unsigned nbytes;
        int unsigned pick;
        int          idx;
        logic [7:0]  lead_b;

        clear_decoder();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].known, directed_rows[i].verdict);

        // random texts: mostly well-formed characters, with a share of broken ones
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            if (random_words < QUIET_TAIL) begin
                pick          = $urandom_range(0, 3);
                in_gap_pct    = (pick < 2) ? 0 : (pick == 2) ? 15 : 40;
                pick          = $urandom_range(0, 3);
                out_stall_pct = (pick < 2) ? 0 : (pick == 2) ? 15 : 40;
            end else begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end

            text_bytes.delete();
            n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                  : $urandom_range(1, 6);
            repeat (n_chars) begin
                kind   = $urandom_range(0, 99);
                nbytes = 0;
                if (kind < 30) begin
                    add_byte(8'($urandom_range(32'h20, 32'h7E)));
                end else if (kind < 35) begin
                    add_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_TAB);
                end else if (kind < 48) begin
                    cp     = $urandom_range(32'h80, 32'h7FF);
                    nbytes = 2;
                end else if (kind < 62) begin
                    // now and then this lands on a surrogate, which is fine
                    cp     = $urandom_range(32'h800, 32'hFFFF);
                    nbytes = 3;
                end else if (kind < 74) begin
                    cp     = $urandom_range(32'h10000, 32'h10FFFF);
                    nbytes = 4;
                end else if (kind < 78) begin
                    // overlong form of any length
                    nbytes = $urandom_range(2, 4);
                    cp     = $urandom_range(0, (nbytes == 2) ? 32'h7F :
                                               (nbytes == 3) ? 32'h7FF : 32'hFFFF);
                end else if (kind < 82) begin
                    cp     = $urandom_range(32'hD800, 32'hDFFF);
                    nbytes = 3;
                end else if (kind < 85) begin
                    cp     = $urandom_range(32'h110000, 32'h1FFFFF);
                    nbytes = 4;
                end else if (kind < 90) begin
                    add_byte(8'($urandom_range(0, 255)));
                end else if (kind < 94) begin
                    pick = $urandom_range(0, 32);
                    add_byte((pick == 32) ? CHAR_DEL : 8'(pick));
                end else begin
                    // stray continuation or a byte that is never a lead
                    add_byte($urandom_range(0, 1) ?
                             8'($urandom_range(32'h80, 32'hBF)) :
                             8'($urandom_range(32'hF8, 32'hFF)));
                end

                if (nbytes != 0) begin
                    case (nbytes)
                        2:       add_byte(LEAD2_PAT | 8'(cp >> 6));
                        3:       add_byte(LEAD3_PAT | 8'(cp >> 12));
                        default: add_byte(LEAD4_PAT | 8'(cp >> 18));
                    endcase
                    for (int k = int'(nbytes) - 2; k >= 0; k--)
                        add_byte(CONT_PAT | 8'((cp >> (6 * k)) & 32'h3F));
                    // occasionally spoil one continuation byte
                    if ($urandom_range(0, 99) < 5) begin
                        idx = text_bytes.size() - 1 - int'($urandom_range(0, nbytes - 2));
                        text_bytes[idx] = 8'($urandom_range(0, 255));
                    end
                end
            end

            // some texts end inside a multi-byte character
            if ($urandom_range(0, 99) < 6) begin
                lead_b = 8'($urandom_range(32'hC2, 32'hF4));
                add_byte(lead_b);
                if (lead_b >= LEAD3_PAT && $urandom_range(0, 1))
                    add_byte(CONT_PAT | 8'($urandom_range(0, 63)));
            end

            foreach (text_bytes[i])
                send_word(text_bytes[i], i == text_bytes.size() - 1, PRED, INVALID);
            random_words += text_bytes.size();
        end
        in_valid <= 1'b0;

        // drain, then wait on so that any extra verdict would be seen
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("%0d texts in %0d words checked: %0d verdicts, %0d valid and %0d invalid",
                 texts_sent, words_sent, verdicts_seen, verdicts_good,
                 verdicts_seen - verdicts_good);
        $display("covered controls, bad leads, overlongs, surrogates, out-of-range and cut-off text");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### utf8_text_validator.f
sv/utv_pkg.sv
sv/utf8_text_validator.sv
sv/utv_checker.sv
tb/sv/tb_utf8_text_validator.sv
